// File: rtl/bmtf_pkg.sv
package bmtf_pkg;

  localparam int SYM_W = 8;
  localparam int ALPHABET_SIZE_DEF = 256;
  localparam logic [SYM_W-1:0] NOT_FOUND = 8'hFF;

  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_INVERSE = 1'b1;

  typedef struct packed {
    logic             shift;
    logic             restore;
    logic [SYM_W-1:0] pos;
    logic [SYM_W-1:0] front;
  } ctrl_t;

endpackage

// File: rtl/byte_move_to_front_coder.sv
// Channel   Direction  Signals                      Contents
// s_        in         s_tvalid s_tready s_tdata    tdata[7:0] symbol_in; tlast last_of_map
//                      s_tlast
// m_        out        m_tvalid m_tready m_tdata    tdata[7:0] symbol_out; tlast last_out
//                      m_tlast
// cfg_      in         cfg_wr_en cfg_wr_data        direction
//
// Each word passes through a lookup across the whole row of cells, then a move
// step in which every cell at or ahead of the chosen place takes its neighbour's entry.
// A new word is taken only once the move step is over, so only one word at a time is in the block.
// Reset restores the list to identity order at the clock edge; the reset is synchronous.
// A result that is still waiting on the output holds the next word in its move step.
module byte_move_to_front_coder #(
  parameter int ALPHABET_SIZE = bmtf_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [bmtf_pkg::SYM_W-1:0] s_tdata,  // [7:0] symbol_in
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [bmtf_pkg::SYM_W-1:0] m_tdata,  // [7:0] symbol_out
  output logic                      m_tlast
);

  localparam int W = bmtf_pkg::SYM_W;
  localparam logic [W:0]   SIZE_EXT = (W+1)'(ALPHABET_SIZE);
  localparam logic [W-1:0] TOP_POS  = W'(ALPHABET_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MOVE = 2'b10
  } state_t;

  state_t          state;
  logic            direction;
  logic [W-1:0]    entry [ALPHABET_SIZE];
  logic            hit   [ALPHABET_SIZE];
  logic [W-1:0]    key;
  logic [W-1:0]    pos_or;
  logic [W-1:0]    val_or;
  logic            found_or;
  logic [W-1:0]    pos_q;
  logic [W-1:0]    val_q;
  logic            found_q;
  logic            last_q;
  logic            out_free;
  logic            leave;
  logic            accept;
  bmtf_pkg::ctrl_t ctrl;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign leave    = (state == ST_MOVE) && out_free;

  always_comb begin
    if (direction == bmtf_pkg::DIR_INVERSE && {1'b0, s_tdata} >= SIZE_EXT) begin
      key = TOP_POS;
    end else begin
      key = s_tdata;
    end
  end

  always_comb begin
    pos_or   = '0;
    val_or   = '0;
    found_or = 1'b0;
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      pos_or   = pos_or | (hit[k] ? W'(k) : '0);
      val_or   = val_or | (hit[k] ? entry[k] : '0);
      found_or = found_or | hit[k];
    end
  end

  assign ctrl.shift   = leave && found_q;
  assign ctrl.restore = leave && last_q;
  assign ctrl.pos     = pos_q;
  assign ctrl.front   = val_q;

  for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
    logic [W-1:0] prev;
    if (g == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = entry[g-1];
    end
    bmtf_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .forward   (direction == bmtf_pkg::DIR_FORWARD),
      .key       (key),
      .prev_entry(prev),
      .ctrl      (ctrl),
      .entry     (entry[g]),
      .hit       (hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= bmtf_pkg::DIR_FORWARD;
    end else if (cfg_wr_en) begin
      direction <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q   <= pos_or;
      val_q   <= val_or;
      found_q <= found_or;
      last_q  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (accept) begin
            state <= ST_MOVE;
          end
        end
        ST_MOVE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (leave) begin
      if (direction == bmtf_pkg::DIR_INVERSE) begin
        m_tdata <= val_q;
      end else if (found_q) begin
        m_tdata <= pos_q;
      end else begin
        m_tdata <= bmtf_pkg::NOT_FOUND;
      end
      m_tlast <= last_q;
    end
  end

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MOVE))
    else $error("accepted word did not enter the move step");

  a_leave_shows: assert property (@(posedge clk) disable iff (rst)
    leave |=> (m_tvalid && state == ST_IDLE))
    else $error("move step ended without a result on the output");

  a_front_after_move: assert property (@(posedge clk) disable iff (rst)
    (leave && found_q && !last_q) |=> (entry[0] == $past(val_q)))
    else $error("chosen entry did not reach the front of the list");

  a_restore_identity: assert property (@(posedge clk) disable iff (rst)
    (leave && last_q) |=> (entry[0] == '0 && entry[ALPHABET_SIZE-1] == TOP_POS))
    else $error("list not back in identity order after the last word");

endmodule

// File: rtl/bmtf_cell.sv
module bmtf_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      forward,
  input  logic [bmtf_pkg::SYM_W-1:0] key,
  input  logic [bmtf_pkg::SYM_W-1:0] prev_entry,
  input  bmtf_pkg::ctrl_t           ctrl,
  output logic [bmtf_pkg::SYM_W-1:0] entry,
  output logic                      hit
);

  localparam logic [bmtf_pkg::SYM_W-1:0] MY_INDEX = bmtf_pkg::SYM_W'(CELL_INDEX);

  logic [bmtf_pkg::SYM_W-1:0] shifted;

  assign hit     = forward ? (entry == key) : (MY_INDEX == key);
  assign shifted = (CELL_INDEX == 0) ? ctrl.front : prev_entry;

  always_ff @(posedge clk) begin
    if (rst || ctrl.restore) begin
      entry <= MY_INDEX;
    end else if (ctrl.shift && (MY_INDEX <= ctrl.pos)) begin
      entry <= shifted;
    end
  end

endmodule
